[design/gcd_pkg.sv]
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants for the great-circle distance pipeline: fixed-point
// formats, reciprocal constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // CORDIC datapath widths
    localparam int ROT_W = 32;          // rotation x, y, z
    localparam int VEC_W = 34;          // vectoring x, y
    localparam int ANG_W = 32;          // phase angle, 2^32 per turn
    localparam int ATAN_LEN = 40;

    // square root chain: 62-bit radicand, 31-bit root
    localparam int SQ_VW = 62;
    localparam int SQ_RW = 31;
    localparam int SQ_MW = 33;

    // haversine term a in Q30, range [0, 2^30]
    localparam int A_W = 31;
    localparam logic [A_W-1:0] ONE_Q30 = 31'h4000_0000;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // degree-to-phase conversion: divide by 45
    localparam int MAG_W = 30;
    localparam int QUO_W = 25;
    localparam int REM_W = 6;
    localparam logic [29:0] DIV_RECIP = 30'd763549742;   // ceil(2^35/45)
    localparam int DIV_RECIP_SH = 35;
    localparam logic [18:0] FRAC_RECIP = 19'd372828;     // ceil(2^24/45)
    localparam int FRAC_RECIP_SH = 24;
    localparam logic [5:0] DIV_K = 6'd45;
    localparam logic [4:0] DIV_HALF = 5'd22;

    // radians-per-phase scaling
    localparam logic [33:0] PI_Q32 = 34'd13493037705;
    localparam int RAD_W = 13;
    localparam logic [RAD_W-1:0] RADIUS_RST = 13'd6371;
    localparam int DIST_W = 25;

    localparam logic [ANG_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0,
        32'd0,         32'd0,         32'd0,         32'd0
    };

endpackage

[design/gcd_phase.sv]
// ----------------------------------------------------------------------------
// gcd_phase
// Converts a signed angle in 2^-20 degree units to a 32-bit phase,
// round(val * 2^SHIFT / 45), halves away from zero, in four stages.
// ----------------------------------------------------------------------------
module gcd_phase #(
    parameter int SHIFT = 8
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [29:0]       i_val,
    output logic [gcd_pkg::ANG_W-1:0] o_phase
);

    localparam int NUM_W = gcd_pkg::REM_W + SHIFT + 1;
    localparam int TP_W = NUM_W + 19;

    logic [gcd_pkg::MAG_W-1:0] r_mag1, r_mag2;
    logic                      r_neg1, r_neg2, r_neg3;
    logic [gcd_pkg::QUO_W-1:0] r_quo2, r_quo3;
    logic [gcd_pkg::REM_W-1:0] r_rem3;
    logic [gcd_pkg::ANG_W-1:0] r_phase;

    logic [59:0]               w_prod;
    logic [gcd_pkg::MAG_W-1:0] w_rem;
    logic [NUM_W-1:0]          w_num;
    logic [TP_W-1:0]           w_tp;
    logic [gcd_pkg::ANG_W-1:0] w_val;

    always_comb begin
        w_prod = 60'(r_mag1) * 60'(gcd_pkg::DIV_RECIP);
        w_rem  = r_mag2 - gcd_pkg::MAG_W'(30'(r_quo2) * 30'(gcd_pkg::DIV_K));
        w_num  = (NUM_W'(r_rem3) << SHIFT) + NUM_W'(gcd_pkg::DIV_HALF);
        w_tp   = TP_W'(w_num) * TP_W'(gcd_pkg::FRAC_RECIP);
        w_val  = (gcd_pkg::ANG_W'(r_quo3) << SHIFT)
               + gcd_pkg::ANG_W'(w_tp >> gcd_pkg::FRAC_RECIP_SH);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag1  <= i_val[29] ? gcd_pkg::MAG_W'(-i_val) : gcd_pkg::MAG_W'(i_val);
            r_neg1  <= i_val[29];
            r_quo2  <= w_prod[gcd_pkg::DIV_RECIP_SH +: gcd_pkg::QUO_W];
            r_mag2  <= r_mag1;
            r_neg2  <= r_neg1;
            r_rem3  <= w_rem[gcd_pkg::REM_W-1:0];
            r_quo3  <= r_quo2;
            r_neg3  <= r_neg2;
            r_phase <= r_neg3 ? -w_val : w_val;
        end
    end

    assign o_phase = r_phase;

endmodule

[design/gcd_rot_cell.sv]
// ----------------------------------------------------------------------------
// gcd_rot_cell
// One rotation-mode CORDIC micro-rotation; passes the quadrant along.
// ----------------------------------------------------------------------------
module gcd_rot_cell #(
    parameter int IDX = 0
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [gcd_pkg::ROT_W-1:0] i_x,
    input  logic signed [gcd_pkg::ROT_W-1:0] i_y,
    input  logic signed [gcd_pkg::ROT_W-1:0] i_z,
    input  logic [1:0]                      i_k,
    output logic signed [gcd_pkg::ROT_W-1:0] o_x,
    output logic signed [gcd_pkg::ROT_W-1:0] o_y,
    output logic signed [gcd_pkg::ROT_W-1:0] o_z,
    output logic [1:0]                      o_k
);

    localparam logic signed [gcd_pkg::ROT_W-1:0] ATAN = gcd_pkg::ATAN_TABLE[IDX];

    logic signed [gcd_pkg::ROT_W-1:0] r_x, r_y, r_z;
    logic [1:0]                       r_k;
    logic signed [gcd_pkg::ROT_W-1:0] w_dx, w_dy;

    assign w_dx = i_y >>> IDX;
    assign w_dy = i_x >>> IDX;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[gcd_pkg::ROT_W-1]) begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + ATAN;
            end
            r_k <= i_k;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_k = r_k;

endmodule

[design/gcd_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// One step of a digit-by-digit integer square root: one root bit per cell.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [gcd_pkg::SQ_VW-1:0]  i_v,
    input  logic [gcd_pkg::SQ_RW-1:0]  i_root,
    input  logic [gcd_pkg::SQ_MW-1:0]  i_rem,
    output logic [gcd_pkg::SQ_VW-1:0]  o_v,
    output logic [gcd_pkg::SQ_RW-1:0]  o_root,
    output logic [gcd_pkg::SQ_MW-1:0]  o_rem
);

    localparam int TW = gcd_pkg::SQ_MW + 2;

    logic [gcd_pkg::SQ_VW-1:0] r_v;
    logic [gcd_pkg::SQ_RW-1:0] r_root;
    logic [gcd_pkg::SQ_MW-1:0] r_rem;
    logic [TW-1:0]             w_acc, w_trial;

    assign w_acc   = {i_rem, i_v[gcd_pkg::SQ_VW-1 -: 2]};
    assign w_trial = TW'({i_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= i_v << 2;
            if (w_acc >= w_trial) begin
                r_rem  <= gcd_pkg::SQ_MW'(w_acc - w_trial);
                r_root <= {i_root[gcd_pkg::SQ_RW-2:0], 1'b1};
            end else begin
                r_rem  <= gcd_pkg::SQ_MW'(w_acc);
                r_root <= {i_root[gcd_pkg::SQ_RW-2:0], 1'b0};
            end
        end
    end

    assign o_v    = r_v;
    assign o_root = r_root;
    assign o_rem  = r_rem;

endmodule

[design/gcd_vec_cell.sv]
// ----------------------------------------------------------------------------
// gcd_vec_cell
// One vectoring-mode CORDIC micro-rotation, accumulating the angle in z.
// ----------------------------------------------------------------------------
module gcd_vec_cell #(
    parameter int IDX = 0
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [gcd_pkg::VEC_W-1:0] i_x,
    input  logic signed [gcd_pkg::VEC_W-1:0] i_y,
    input  logic signed [gcd_pkg::ANG_W-1:0] i_z,
    output logic signed [gcd_pkg::VEC_W-1:0] o_x,
    output logic signed [gcd_pkg::VEC_W-1:0] o_y,
    output logic signed [gcd_pkg::ANG_W-1:0] o_z
);

    localparam logic signed [gcd_pkg::ANG_W-1:0] ATAN = gcd_pkg::ATAN_TABLE[IDX];

    logic signed [gcd_pkg::VEC_W-1:0] r_x, r_y;
    logic signed [gcd_pkg::ANG_W-1:0] r_z;
    logic signed [gcd_pkg::VEC_W-1:0] w_dx, w_dy;

    assign w_dx = i_y >>> IDX;
    assign w_dy = i_x >>> IDX;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[gcd_pkg::VEC_W-1]) begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + ATAN;
            end else begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - ATAN;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

[design/great_circle_distance.sv]
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine great-circle distance between two points, fully pipelined.
// ----------------------------------------------------------------------------
// Slave stream carries one point pair per request; master stream returns the
// distance in 1/1024 km, rounded to nearest. i_cfg_we loads the sphere radius
// in whole km (reset value 6371); write it only while the pipeline is empty.
// Throughput: one request per cycle while the master side is not stalled.
// From accept to o_m_axis_tvalid a request passes the cell chains, with
// N = min(CORDIC_ITERATIONS, 40): 4 stages of degree-to-phase
// conversion, N rotation cells, 3 haversine multiply stages, 31 square-root
// cells, N vectoring cells and 3 radius-scaling stages ending in the output
// register. The whole pipeline advances when the output register is empty or
// taken, so a stall on the master side freezes every stage and deasserts
// o_s_axis_tready; nothing is dropped. Reset empties the pipeline and restores
// the default radius.
// ----------------------------------------------------------------------------
module great_circle_distance #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [12:0]  i_cfg_wdata,     // sphere_radius_km
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [27:0] first_latitude, [56:28] first_longitude,
    // [84:57] second_latitude, [113:85] second_longitude, [119:114] zero
    input  logic [119:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [24:0] distance, [31:25] zero
    output logic [31:0]  o_m_axis_tdata
);

    localparam int N = (CORDIC_ITERATIONS > gcd_pkg::ATAN_LEN) ?
                       gcd_pkg::ATAN_LEN : CORDIC_ITERATIONS;
    localparam int LAT = 41 + 2 * N;
    localparam int RW = gcd_pkg::ROT_W;
    localparam int VW = gcd_pkg::VEC_W;

    logic                 w_adv;
    logic [LAT-1:0]       r_vld;
    logic [gcd_pkg::RAD_W-1:0] r_radius;

    assign w_adv           = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= gcd_pkg::RADIUS_RST;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
            end
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
        end
    end

    // ---- input fields and phase conversion ----
    logic signed [27:0] w_lat1, w_lat2;
    logic signed [28:0] w_lon1, w_lon2;
    logic signed [29:0] w_cin [4];
    logic [gcd_pkg::ANG_W-1:0] w_phase [4];

    assign w_lat1 = i_s_axis_tdata[27:0];
    assign w_lon1 = i_s_axis_tdata[56:28];
    assign w_lat2 = i_s_axis_tdata[84:57];
    assign w_lon2 = i_s_axis_tdata[113:85];

    assign w_cin[0] = 30'(w_lat2) - 30'(w_lat1);
    assign w_cin[1] = 30'(w_lon2) - 30'(w_lon1);
    assign w_cin[2] = 30'(w_lat1);
    assign w_cin[3] = 30'(w_lat2);

    genvar gc, gi;
    generate
        for (gc = 0; gc < 4; gc++) begin : g_conv
            gcd_phase #(.SHIFT(gc < 2 ? 8 : 9)) u_phase (
                .i_clk   (i_clk),
                .i_en    (w_adv),
                .i_val   (w_cin[gc]),
                .o_phase (w_phase[gc])
            );
        end
    endgenerate

    // ---- rotation CORDIC chains: sin(dlat/2), sin(dlon/2), cos(lat1), cos(lat2)
    logic signed [RW-1:0] w_rx [4][N+1];
    logic signed [RW-1:0] w_ry [4][N+1];
    logic signed [RW-1:0] w_rz [4][N+1];
    logic [1:0]           w_rk [4][N+1];

    generate
        for (gc = 0; gc < 4; gc++) begin : g_rot
            logic [gcd_pkg::ANG_W-1:0] w_q;
            assign w_q = w_phase[gc] + 32'h2000_0000;
            assign w_rx[gc][0] = gcd_pkg::CORDIC_GAIN;
            assign w_ry[gc][0] = '0;
            assign w_rz[gc][0] = $signed({2'b00, w_q[29:0]}) - 32'sh2000_0000;
            assign w_rk[gc][0] = w_q[31:30];
            for (gi = 0; gi < N; gi++) begin : g_cell
                gcd_rot_cell #(.IDX(gi)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_adv),
                    .i_x   (w_rx[gc][gi]),
                    .i_y   (w_ry[gc][gi]),
                    .i_z   (w_rz[gc][gi]),
                    .i_k   (w_rk[gc][gi]),
                    .o_x   (w_rx[gc][gi+1]),
                    .o_y   (w_ry[gc][gi+1]),
                    .o_z   (w_rz[gc][gi+1]),
                    .o_k   (w_rk[gc][gi+1])
                );
            end
        end
    endgenerate

    // quadrant fold: sine for chains 0 and 1, cosine for chains 2 and 3
    logic signed [RW:0] w_trig [4];
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            unique case (w_rk[c][N])
                2'd0: w_trig[c] = (c < 2) ?  (RW+1)'(w_ry[c][N]) :  (RW+1)'(w_rx[c][N]);
                2'd1: w_trig[c] = (c < 2) ?  (RW+1)'(w_rx[c][N]) : -(RW+1)'(w_ry[c][N]);
                2'd2: w_trig[c] = (c < 2) ? -(RW+1)'(w_ry[c][N]) : -(RW+1)'(w_rx[c][N]);
                default: w_trig[c] = (c < 2) ? -(RW+1)'(w_rx[c][N]) : (RW+1)'(w_ry[c][N]);
            endcase
        end
    end

    // ---- haversine term ----
    logic signed [65:0] w_p_dl, w_p_dn, w_p_cc;
    logic signed [34:0] r_sdl2, r_sdn2, r_cc, r_sdl2_b;
    logic signed [69:0] w_p_t;
    logic signed [36:0] r_t;
    logic signed [37:0] w_sum;
    logic [gcd_pkg::A_W-1:0] r_a, r_b;

    assign w_p_dl = 66'(w_trig[0]) * 66'(w_trig[0]);
    assign w_p_dn = 66'(w_trig[1]) * 66'(w_trig[1]);
    assign w_p_cc = 66'(w_trig[2]) * 66'(w_trig[3]);
    assign w_p_t  = 70'(r_cc) * 70'(r_sdn2);
    assign w_sum  = 38'(r_sdl2_b) + 38'(r_t);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sdl2   <= w_p_dl[64:30];
            r_sdn2   <= w_p_dn[64:30];
            r_cc     <= w_p_cc[64:30];
            r_t      <= w_p_t[66:30];
            r_sdl2_b <= r_sdl2;
            priority if (w_sum < 0) begin
                r_a <= '0;
                r_b <= gcd_pkg::ONE_Q30;
            end else if (w_sum > 38'(gcd_pkg::ONE_Q30)) begin
                r_a <= gcd_pkg::ONE_Q30;
                r_b <= '0;
            end else begin
                r_a <= w_sum[gcd_pkg::A_W-1:0];
                r_b <= gcd_pkg::ONE_Q30 - w_sum[gcd_pkg::A_W-1:0];
            end
        end
    end

    // ---- square roots of a and 1-a ----
    logic [gcd_pkg::SQ_VW-1:0] w_sv [2][gcd_pkg::SQ_RW+1];
    logic [gcd_pkg::SQ_RW-1:0] w_sr [2][gcd_pkg::SQ_RW+1];
    logic [gcd_pkg::SQ_MW-1:0] w_sm [2][gcd_pkg::SQ_RW+1];

    assign w_sv[0][0] = {1'b0, r_a, 30'd0};
    assign w_sv[1][0] = {1'b0, r_b, 30'd0};

    generate
        for (gc = 0; gc < 2; gc++) begin : g_sqrt
            assign w_sr[gc][0] = '0;
            assign w_sm[gc][0] = '0;
            for (gi = 0; gi < gcd_pkg::SQ_RW; gi++) begin : g_cell
                gcd_sqrt_cell u_cell (
                    .i_clk  (i_clk),
                    .i_en   (w_adv),
                    .i_v    (w_sv[gc][gi]),
                    .i_root (w_sr[gc][gi]),
                    .i_rem  (w_sm[gc][gi]),
                    .o_v    (w_sv[gc][gi+1]),
                    .o_root (w_sr[gc][gi+1]),
                    .o_rem  (w_sm[gc][gi+1])
                );
            end
        end
    endgenerate

    // ---- vectoring CORDIC: atan2(sqrt a, sqrt(1-a)) ----
    logic signed [VW-1:0] w_vx [N+1];
    logic signed [VW-1:0] w_vy [N+1];
    logic signed [gcd_pkg::ANG_W-1:0] w_vz [N+1];

    assign w_vx[0] = VW'(w_sr[1][gcd_pkg::SQ_RW]);
    assign w_vy[0] = VW'(w_sr[0][gcd_pkg::SQ_RW]);
    assign w_vz[0] = '0;

    generate
        for (gi = 0; gi < N; gi++) begin : g_vec
            gcd_vec_cell #(.IDX(gi)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_x   (w_vx[gi]),
                .i_y   (w_vy[gi]),
                .i_z   (w_vz[gi]),
                .o_x   (w_vx[gi+1]),
                .o_y   (w_vy[gi+1]),
                .o_z   (w_vz[gi+1])
            );
        end
    endgenerate

    // ---- radius scaling: (R * z * pi_q32 + 2^51) >> 52 ----
    logic [gcd_pkg::ANG_W-2:0] w_zc;
    logic [43:0]               r_p;
    logic [56:0]               r_big_a;
    logic [54:0]               r_big_b;
    logic [55:0]               w_low;
    logic [25:0]               w_dist;
    logic [gcd_pkg::DIST_W-1:0] r_dist;

    assign w_zc   = w_vz[N][gcd_pkg::ANG_W-1] ? '0 : w_vz[N][gcd_pkg::ANG_W-2:0];
    assign w_low  = 56'({r_big_a[30:0], 21'd0}) + 56'(r_big_b) + (56'd1 << 51);
    assign w_dist = r_big_a[56:31] + 26'(w_low[55:52]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p     <= 44'(r_radius) * 44'(w_zc);
            r_big_a <= 57'(r_p[43:21]) * 57'(gcd_pkg::PI_Q32);
            r_big_b <= 55'(r_p[20:0]) * 55'(gcd_pkg::PI_Q32);
            r_dist  <= w_dist[gcd_pkg::DIST_W-1:0];
        end
    end

    assign o_m_axis_tdata = {7'd0, r_dist};

endmodule
